// ----- rtl/core/eqbs_pkg.sv -----
// Shared types, constants and op codes of the eight-queens backtracking search.
// No dependencies; the datapath, controller and top level refer to it by scoped names, the testbench imports it.
package eqbs_pkg;

	// Board defaults and fixed field widths
	localparam int BOARD_SIZE_DEF = 8;
	localparam int MAX_ROWS       = 8;
	localparam int COL_FIELD_W    = 3;
	localparam int PACKED_W       = MAX_ROWS * COL_FIELD_W;

	// Op codes of a request beat
	localparam logic [1:0] OP_PLACE = 2'd0;
	localparam logic [1:0] OP_NEXT  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Request payload
	typedef struct packed {
		logic [1:0]             op;
		logic [COL_FIELD_W-1:0] preset_row;
		logic [COL_FIELD_W-1:0] preset_col;
	} req_t;

	// Response payload
	typedef struct packed {
		logic                solution_found;
		logic [PACKED_W-1:0] queen_columns;
	} rsp_t;

	// Controller to datapath commands, at most one set per cycle
	typedef struct packed {
		logic clear;        // reset board and search
		logic place;        // record a preset queen from the request
		logic start;        // first search: row 0, column 0
		logic init_back;    // resume: row at board end, backtrack
		logic dec_row;      // step one row back
		logic load_back;    // lift queen of current row, resume at next column
		logic skip_row;     // pass a fixed row
		logic col_inc;      // try next column
		logic put_queen;    // place queen at current cell, advance row
		logic set_exh;      // mark search exhausted
		logic load_result;  // capture response beat
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic started;
		logic exhausted;
		logic row_zero;
		logic at_end;
		logic row_fixed;
		logic col_end;
		logic cell_free;
	} sts_t;

endpackage

// ----- rtl/core/eqbs_stream_if.sv -----
// Valid/ready stream channel carrying one payload per beat.
// Depends on nothing; the payload type is given at instantiation.
interface eqbs_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/eqbs_datapath.sv -----
// Board state, search counters and response register of the queens search.
// Depends on eqbs_pkg for command, status and field widths.
module eqbs_datapath #(
	parameter int BOARD_SIZE = eqbs_pkg::BOARD_SIZE_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  eqbs_pkg::cmd_t                      cmd,
	input  logic [eqbs_pkg::COL_FIELD_W-1:0]    preset_row,
	input  logic [eqbs_pkg::COL_FIELD_W-1:0]    preset_col,
	output eqbs_pkg::sts_t                      sts,
	output logic                                solution_found,
	output logic [eqbs_pkg::PACKED_W-1:0]       queen_columns
);

	localparam int IDX_W  = $clog2(BOARD_SIZE);
	localparam int ROW_W  = $clog2(BOARD_SIZE + 1);
	localparam int DIAG_W = 2 * BOARD_SIZE - 1;
	localparam int DIW    = $clog2(DIAG_W);
	localparam int FW     = eqbs_pkg::COL_FIELD_W;

	logic [BOARD_SIZE-1:0] col_taken_q;
	logic [DIAG_W-1:0]     rise_taken_q;
	logic [DIAG_W-1:0]     fall_taken_q;
	logic [BOARD_SIZE-1:0] fixed_rows_q;
	logic [FW-1:0]         queen_col_q [BOARD_SIZE];
	logic [ROW_W-1:0]      row_q;
	logic [ROW_W-1:0]      col_q;
	logic                  started_q;
	logic                  exhausted_q;
	logic                  rsp_found_q;
	logic [eqbs_pkg::PACKED_W-1:0] rsp_cols_q;

	logic [IDX_W-1:0]      cur_r;
	logic [IDX_W-1:0]      cur_c;
	logic [IDX_W-1:0]      back_c;
	logic [IDX_W-1:0]      mark_r;
	logic [IDX_W-1:0]      mark_c;
	logic [DIW-1:0]        scan_rise;
	logic [DIW-1:0]        scan_fall;
	logic [DIW-1:0]        mark_rise;
	logic [DIW-1:0]        mark_fall;
	logic [DIW-1:0]        back_rise;
	logic [DIW-1:0]        back_fall;
	logic                  preset_ok;
	logic [eqbs_pkg::PACKED_W-1:0] packed_cols;

	function automatic logic [DIAG_W-1:0] diag_bit(input logic [DIW-1:0] idx);
		return DIAG_W'(1) << idx;
	endfunction

	function automatic logic [DIW-1:0] rise_idx(input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c);
		return DIW'(r) + DIW'(c);
	endfunction

	function automatic logic [DIW-1:0] fall_idx(input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c);
		return DIW'(r) + DIW'(BOARD_SIZE - 1) - DIW'(c);
	endfunction

	// Decode cell coordinates for scan, backtrack and mark paths
	assign cur_r     = row_q[IDX_W-1:0];
	assign cur_c     = col_q[IDX_W-1:0];
	assign back_c    = queen_col_q[cur_r][IDX_W-1:0];
	assign mark_r    = cmd.place ? preset_row[IDX_W-1:0] : cur_r;
	assign mark_c    = cmd.place ? preset_col[IDX_W-1:0] : cur_c;
	assign scan_rise = rise_idx(cur_r, cur_c);
	assign scan_fall = fall_idx(cur_r, cur_c);
	assign mark_rise = rise_idx(mark_r, mark_c);
	assign mark_fall = fall_idx(mark_r, mark_c);
	assign back_rise = rise_idx(cur_r, back_c);
	assign back_fall = fall_idx(cur_r, back_c);
	assign preset_ok = (int'(preset_row) < BOARD_SIZE) && (int'(preset_col) < BOARD_SIZE);

	// Pack queen columns, rows past the board stay zero
	always_comb begin
		packed_cols = '0;
		for (int k = 0; k < BOARD_SIZE; k++) begin
			packed_cols[k*FW +: FW] = queen_col_q[k];
		end
	end

	// Report status to the controller
	assign sts.started   = started_q;
	assign sts.exhausted = exhausted_q;
	assign sts.row_zero  = (row_q == '0);
	assign sts.at_end    = (row_q == ROW_W'(BOARD_SIZE));
	assign sts.row_fixed = fixed_rows_q[cur_r];
	assign sts.col_end   = (col_q == ROW_W'(BOARD_SIZE));
	assign sts.cell_free = !col_taken_q[cur_c] && !rise_taken_q[scan_rise]
		&& !fall_taken_q[scan_fall];

	// Update board and search position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_taken_q  <= '0;
			rise_taken_q <= '0;
			fall_taken_q <= '0;
			fixed_rows_q <= '0;
			for (int k = 0; k < BOARD_SIZE; k++) queen_col_q[k] <= '0;
			row_q        <= '0;
			col_q        <= '0;
			started_q    <= 1'b0;
			exhausted_q  <= 1'b0;
		end else begin
			priority if (cmd.clear) begin
				col_taken_q  <= '0;
				rise_taken_q <= '0;
				fall_taken_q <= '0;
				fixed_rows_q <= '0;
				for (int k = 0; k < BOARD_SIZE; k++) queen_col_q[k] <= '0;
				row_q        <= '0;
				col_q        <= '0;
				started_q    <= 1'b0;
				exhausted_q  <= 1'b0;
			end else if (cmd.place) begin
				if (preset_ok) begin
					fixed_rows_q[mark_r] <= 1'b1;
					col_taken_q[mark_c]  <= 1'b1;
					rise_taken_q         <= rise_taken_q | diag_bit(mark_rise);
					fall_taken_q         <= fall_taken_q | diag_bit(mark_fall);
					queen_col_q[mark_r]  <= preset_col;
				end
			end else if (cmd.start) begin
				started_q <= 1'b1;
				row_q     <= '0;
				col_q     <= '0;
			end else if (cmd.init_back) begin
				row_q <= ROW_W'(BOARD_SIZE);
			end else if (cmd.dec_row) begin
				row_q <= row_q - ROW_W'(1);
			end else if (cmd.load_back) begin
				col_taken_q[back_c] <= 1'b0;
				rise_taken_q        <= rise_taken_q & ~diag_bit(back_rise);
				fall_taken_q        <= fall_taken_q & ~diag_bit(back_fall);
				col_q               <= ROW_W'(back_c) + ROW_W'(1);
			end else if (cmd.skip_row) begin
				row_q <= row_q + ROW_W'(1);
				col_q <= '0;
			end else if (cmd.col_inc) begin
				col_q <= col_q + ROW_W'(1);
			end else if (cmd.put_queen) begin
				queen_col_q[cur_r]  <= FW'(cur_c);
				col_taken_q[cur_c]  <= 1'b1;
				rise_taken_q        <= rise_taken_q | diag_bit(scan_rise);
				fall_taken_q        <= fall_taken_q | diag_bit(scan_fall);
				row_q               <= row_q + ROW_W'(1);
				col_q               <= '0;
			end else if (cmd.set_exh) begin
				exhausted_q <= 1'b1;
			end
		end
	end

	// Capture the response beat
	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			rsp_found_q <= !exhausted_q;
			rsp_cols_q  <= exhausted_q ? '0 : packed_cols;
		end
	end

	assign solution_found = rsp_found_q;
	assign queen_columns  = rsp_cols_q;

endmodule

// ----- rtl/core/eqbs_ctrl.sv -----
// Controller state machine of the queens search: decodes requests, walks the
// backtracking loop one step a cycle and hands over the response beat.
// Depends on eqbs_pkg for op codes, commands and status.
module eqbs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic [1:0]     req_op,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  eqbs_pkg::sts_t sts,
	output eqbs_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADV,
		S_SCAN,
		S_BACK,
		S_BCHK,
		S_RESP
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   rsp_free;

	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// Decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					unique case (req_op)
						eqbs_pkg::OP_PLACE: cmd.place = !sts.started;
						eqbs_pkg::OP_CLEAR: cmd.clear = 1'b1;
						eqbs_pkg::OP_NEXT: begin
							priority if (sts.started && sts.exhausted) begin
								state_d = S_RESP;
							end else if (!sts.started) begin
								cmd.start = 1'b1;
								state_d   = S_ADV;
							end else begin
								cmd.init_back = 1'b1;
								state_d       = S_BACK;
							end
						end
						default: ;
					endcase
				end
			end
			S_ADV: begin
				priority if (sts.at_end) begin
					state_d = S_RESP;
				end else if (sts.row_fixed) begin
					cmd.skip_row = 1'b1;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				priority if (sts.col_end) begin
					state_d = S_BACK;
				end else if (sts.cell_free) begin
					cmd.put_queen = 1'b1;
					state_d       = S_ADV;
				end else begin
					cmd.col_inc = 1'b1;
				end
			end
			S_BACK: begin
				if (sts.row_zero) begin
					cmd.set_exh = 1'b1;
					state_d     = S_RESP;
				end else begin
					cmd.dec_row = 1'b1;
					state_d     = S_BCHK;
				end
			end
			S_BCHK: begin
				if (sts.row_fixed) begin
					state_d = S_BACK;
				end else begin
					cmd.load_back = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_RESP: begin
				if (rsp_free) begin
					cmd.load_result = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_result) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// A response appears only out of the response state
	a_rsp_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_RESP))
		else $error("response raised outside response state");

	// The search loop runs only on a started board
	a_search_started: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADV || state_q == S_SCAN || state_q == S_BACK || state_q == S_BCHK)
		|-> sts.started)
		else $error("search step on a board that was not started");

	// Column scan and backtrack check stay on a board row
	a_scan_on_board: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_BCHK) |-> !sts.at_end)
		else $error("cell scan past the last row");

	// An exhausted search leaves straight through the response state
	a_exh_to_resp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_exh |=> (state_q == S_RESP) && sts.exhausted)
		else $error("exhaustion not followed by response");

endmodule

// ----- rtl/core/eight_queens_backtrack_search.sv -----
// Top level of the eight-queens backtracking search.
// Depends on eqbs_pkg, eqbs_stream_if, eqbs_ctrl and eqbs_datapath.
//
// Usage:
//   req carries one request beat: op, preset_row, preset_col. A place beat
//   fixes a row with a queen before the search starts; a clear beat resets
//   the board and the search; a next beat resumes the depth-first search.
//   Each place or clear beat gives no response.
//   rsp carries one beat per next request: solution_found and the packed
//   columns, row r in bits 3r+2..3r, zero when the search is exhausted.
//   A next request is worked by the controller loop one cell test at a time.
//   req is ready only between requests; one request is worked at a time.
//   A finished response waits in the output register while the next request
//   is taken; a further response waits until rsp.ready drains the first.
//   Reset (arst_n low) clears the board, the search and the output valid.
module eight_queens_backtrack_search #(
	parameter int BOARD_SIZE = eqbs_pkg::BOARD_SIZE_DEF
) (
	input logic          clk,
	input logic          arst_n,
	eqbs_stream_if.sink   req,
	eqbs_stream_if.source rsp
);

	eqbs_pkg::cmd_t cmd;
	eqbs_pkg::sts_t sts;
	logic           req_ready;
	logic           rsp_valid;
	logic           found;
	logic [eqbs_pkg::PACKED_W-1:0] cols;

	// Sequence requests and the search loop
	eqbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_op    (req.data.op),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hold the board and build the response
	eqbs_datapath #(
		.BOARD_SIZE (BOARD_SIZE)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.preset_row     (req.data.preset_row),
		.preset_col     (req.data.preset_col),
		.sts            (sts),
		.solution_found (found),
		.queen_columns  (cols)
	);

	assign req.ready                = req_ready;
	assign rsp.valid                = rsp_valid;
	assign rsp.data.solution_found  = found;
	assign rsp.data.queen_columns   = cols;

endmodule

// ----- verif/tb_eight_queens_backtrack_search.sv -----
// Testbench of the eight-queens backtracking search: directed and random request beats
// are checked against an internal search predictor in a scoreboard class.
// Depends on eqbs_pkg, eqbs_stream_if and eight_queens_backtrack_search.
`timescale 1ns / 100ps

module tb_eight_queens_backtrack_search;
	import eqbs_pkg::*;

	localparam int         BOARD     = BOARD_SIZE_DEF;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [3:0] DEPTH_DONE = 4'd15;
	localparam int         CYCLE_LIMIT = 40_000_000;
	localparam int         RANDOM_ITEMS = 300;
	localparam int         LONG_HOLD = 3000;

	// Predicts every answer beat and holds the answers still to arrive
	class queens_scoreboard;
		logic [7:0]  col_used;
		logic [14:0] rise_used;
		logic [14:0] fall_used;
		logic [7:0]  fixed_row;
		logic [2:0]  queen_col[MAX_ROWS];
		logic [3:0]  depth;
		logic        started;
		rsp_t        answers_due[$];
		int          errors;

		function new();
			errors = 0;
			clear_board();
		endfunction

		function void clear_board();
			col_used  = '0;
			rise_used = '0;
			fall_used = '0;
			fixed_row = '0;
			depth     = '0;
			started   = 1'b0;
			for (int k = 0; k < MAX_ROWS; k++)
				queen_col[k] = '0;
		endfunction

		function bit cell_open(int r, int c);
			return !col_used[c] && !rise_used[r + c] && !fall_used[r + BOARD - 1 - c];
		endfunction

		function void set_marks(int r, int c, bit v);
			col_used[c]                 = v;
			rise_used[r + c]            = v;
			fall_used[r + BOARD - 1 - c] = v;
		endfunction

		// Resume the depth-first walk and return the next placement or exhaustion
		function rsp_t next_placement();
			rsp_t ans;
			int   r;
			int   c;
			bit   back;
			ans = '0;
			if (started && depth == DEPTH_DONE)
				return ans;
			if (!started) begin
				started = 1'b1;
				r = 0;
				back = 1'b0;
			end else begin
				r = BOARD;
				back = 1'b1;
			end
			c = 0;
			while (1'b1) begin
				if (back) begin
					// step back over fixed rows to the last searched row
					while (1'b1) begin
						if (r == 0) begin
							depth = DEPTH_DONE;
							return ans;
						end
						r--;
						if (!fixed_row[r])
							break;
					end
					c = int'(queen_col[r]);
					set_marks(r, c, 1'b0);
					c++;
					back = 1'b0;
				end
				if (r >= BOARD) begin
					for (int k = 0; k < BOARD; k++)
						ans.queen_columns[3*k +: 3] = queen_col[k];
					ans.solution_found = 1'b1;
					depth = 4'(BOARD);
					return ans;
				end
				if (fixed_row[r]) begin
					r++;
					c = 0;
					continue;
				end
				while (c < BOARD && !cell_open(r, c))
					c++;
				if (c < BOARD) begin
					queen_col[r] = 3'(c);
					set_marks(r, c, 1'b1);
					r++;
					c = 0;
				end else begin
					back = 1'b1;
				end
			end
			return ans;
		endfunction

		// Apply one accepted request beat to the board copy
		function void note_request(req_t q);
			case (q.op)
				OP_CLEAR: clear_board();
				OP_PLACE: begin
					if (!started && q.preset_row < BOARD && q.preset_col < BOARD) begin
						fixed_row[q.preset_row] = 1'b1;
						set_marks(q.preset_row, q.preset_col, 1'b1);
						queen_col[q.preset_row] = q.preset_col;
					end
				end
				OP_NEXT: answers_due.push_back(next_placement());
				default: ;
			endcase
		endfunction

		// Compare one answer beat with the oldest prediction
		function void check_response(rsp_t got);
			rsp_t want;
			if (answers_due.size() == 0) begin
				$display("%0t: unexpected answer beat found=%0b columns=%h",
					$time, got.solution_found, got.queen_columns);
				errors++;
				return;
			end
			want = answers_due.pop_front();
			if (got.solution_found !== want.solution_found) begin
				$display("%0t: solution_found expected %0b actual %0b",
					$time, want.solution_found, got.solution_found);
				errors++;
			end
			if (got.queen_columns !== want.queen_columns) begin
				$display("%0t: queen_columns expected %h actual %h",
					$time, want.queen_columns, got.queen_columns);
				errors++;
			end
		endfunction

		function int outstanding();
			return answers_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	eqbs_stream_if #(.payload_t(req_t)) req_if ();
	eqbs_stream_if #(.payload_t(rsp_t)) rsp_if ();

	eight_queens_backtrack_search dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	queens_scoreboard sb;
	int               burst_left = 0;
	int               beats_sent = 0;
	int               cycle_count = 0;
	bit               long_hold_pending = 1'b0;
	bit               long_hold_done = 1'b0;

	always #10 clk = ~clk;

	// Offer one request beat, with a random gap whenever a burst runs out
	task automatic offer(input logic [1:0] op, input int row, input int col);
		req_t beat;
		beat.op         = op;
		beat.preset_row = row[2:0];
		beat.preset_col = col[2:0];
		if (burst_left == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= beat;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		sb.note_request(beat);
		burst_left--;
		beats_sent++;
	endtask

	// Hold the request side until every answer has arrived
	task automatic drain();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() > 0);
	endtask

	// Random search session: noise beats of any op code, or an optional clear, presets, then a run of next beats
	task automatic random_session();
		int kind;
		int count;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			// noise: any op code, unused one included
			repeat ($urandom_range(1, 4))
				offer(2'($urandom_range(0, 3)), $urandom_range(0, 7), $urandom_range(0, 7));
			return;
		end
		if ($urandom_range(0, 9) != 0)
			offer(OP_CLEAR, $urandom_range(0, 7), $urandom_range(0, 7));
		if (kind == 1) begin
			for (int r = 0; r < BOARD; r++)
				offer(OP_PLACE, r, $urandom_range(0, 7));
		end else begin
			repeat ($urandom_range(0, 4))
				offer(OP_PLACE, $urandom_range(0, 7), $urandom_range(0, 7));
		end
		count = $urandom_range(1, 12);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 15) == 0)
				offer(OP_PLACE, $urandom_range(0, 7), $urandom_range(0, 7));
			offer(OP_NEXT, $urandom_range(0, 7), $urandom_range(0, 7));
		end
	endtask

	// Receiver: check answer beats and stall on its own pattern
	initial begin : answer_sink
		int phase_left;
		int stall_mode;
		int hold_left;
		phase_left = 0;
		stall_mode = 0;
		hold_left  = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_if.valid && rsp_if.ready)
				sb.check_response(rsp_if.data);
			if (long_hold_pending && !long_hold_done) begin
				hold_left = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (phase_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				phase_left = $urandom_range(20, 200);
			end
			phase_left--;
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				case (stall_mode)
					0: rsp_if.ready <= 1'b1;
					1: rsp_if.ready <= 1'($urandom_range(0, 1));
					2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
					default: rsp_if.ready <= (phase_left % 16) >= 5;
				endcase
			end
		end
	end

	// Stop a hung run
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[eight_queens_backtrack_search] ERROR");
		$finish;
	end

	initial begin : stimulus
		sb = new();
		arst_n       = 1'b0;
		req_if.valid = 1'b0;
		req_if.data  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty board straight after reset
		offer(OP_NEXT, 0, 0);
		offer(OP_NEXT, 7, 7);
		// preset after the search has started is dropped
		offer(OP_PLACE, 0, 0);
		offer(OP_UNUSED, 7, 7);
		offer(OP_CLEAR, 0, 0);
		// every row fixed, conflicting presets, one row overwritten
		offer(OP_PLACE, 0, 0);
		for (int r = 1; r < BOARD - 1; r++)
			offer(OP_PLACE, r, $urandom_range(1, 6));
		offer(OP_PLACE, 3, 7);
		offer(OP_PLACE, 7, 7);
		offer(OP_NEXT, 0, 0);
		offer(OP_NEXT, 0, 0);
		offer(OP_NEXT, 0, 0);
		offer(OP_CLEAR, 7, 7);
		offer(OP_PLACE, 7, 0);
		offer(OP_PLACE, 0, 7);
		offer(OP_NEXT, 0, 0);
		offer(OP_NEXT, 0, 0);
		drain();

		// Long receiver hold-off while next beats keep coming
		offer(OP_CLEAR, 0, 0);
		offer(OP_PLACE, 0, 0);
		offer(OP_PLACE, 1, 4);
		long_hold_pending = 1'b1;
		repeat (8) offer(OP_NEXT, 0, 0);
		drain();

		// Random sessions, now and then paused until all answers are in
		while (beats_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 5) == 0)
				drain();
			random_session();
		end

		drain();
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("[eight_queens_backtrack_search] OK");
		else
			$display("[eight_queens_backtrack_search] ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/eqbs_pkg.sv
rtl/core/eqbs_stream_if.sv
rtl/core/eqbs_datapath.sv
rtl/core/eqbs_ctrl.sv
rtl/core/eight_queens_backtrack_search.sv
verif/tb_eight_queens_backtrack_search.sv
